/* design/base64_encoder_wrapped_unit_assert.svh */
// Assertion macros shared by the encoder modules.
// Each expects clk and rst in scope.
`ifndef BASE64_ENCODER_WRAPPED_UNIT_ASSERT_SVH
`define BASE64_ENCODER_WRAPPED_UNIT_ASSERT_SVH

// same-cycle implication
`define B64E_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define B64E_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/b64e_pkg.sv */
package b64e_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [10:0] LINE_MAX = 11'h7FF;
  localparam logic [9:0]  MAXLEN_RESET = 10'd60;

  localparam logic REG_URL    = 1'b0;
  localparam logic REG_MAXLEN = 1'b1;

  localparam logic [6:0] CHAR_NL  = 7'h0A;
  localparam logic [6:0] CHAR_PAD = 7'h3D;

  typedef struct packed {
    logic            nl;
    logic [3:0][5:0] sx;
    logic [2:0]      nsym;
    logic [1:0]      npad;
    logic            url;
  } job_t;

  function automatic logic [6:0] sym(input logic [5:0] v, input logic url);
    logic [6:0] c;
    if (v < 6'd26) c = 7'd65 + {1'b0, v};
    else if (v < 6'd52) c = 7'd97 + {1'b0, v - 6'd26};
    else if (v < 6'd62) c = 7'd48 + {1'b0, v - 6'd52};
    else if (v == 6'd62) c = url ? 7'h2D : 7'h2B;
    else c = url ? 7'h5F : 7'h2F;
    return c;
  endfunction

endpackage

/* design/b64e_front.sv */
module b64e_front import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       push,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       q_full,
  output logic       q_push,
  output job_t       q_job
);

  `include "base64_encoder_wrapped_unit_assert.svh"

  logic        url_alphabet;
  logic [9:0]  max_line_length;
  logic [15:0] held;
  logic [1:0]  pos;
  logic [10:0] line_count;

  logic [15:0] held_next;
  logic [1:0]  pos_next;
  logic [10:0] line_count_next;
  logic        emit;
  logic        nl;
  logic [11:0] cnt_sum;
  logic        accept;
  job_t        job;

  assign accept = push && !q_full;

  always_comb begin
    job = '0;
    job.url = url_alphabet;
    emit = 1'b0;
    nl = 1'b0;
    cnt_sum = '0;
    held_next = held;
    pos_next = pos;
    line_count_next = line_count;
    if (pos >= 2'd2) begin
      emit = 1'b1;
      nl = (max_line_length != 10'd0) && (line_count >= {1'b0, max_line_length});
      cnt_sum = {1'b0, (nl ? 11'd0 : line_count)} + 12'd4;
      line_count_next = (cnt_sum > {1'b0, LINE_MAX}) ? LINE_MAX : cnt_sum[10:0];
      job.nl = nl;
      job.sx[0] = held[15:10];
      job.sx[1] = {held[9:8], held[7:4]};
      job.sx[2] = {held[3:0], data_byte[7:6]};
      job.sx[3] = data_byte[5:0];
      job.nsym = 3'd4;
      job.npad = 2'd0;
      held_next = '0;
      pos_next = 2'd0;
    end else if (last_byte) begin
      emit = 1'b1;
      if (pos == 2'd0) begin
        job.sx[0] = data_byte[7:2];
        job.sx[1] = {data_byte[1:0], 4'd0};
        job.nsym = 3'd2;
        job.npad = url_alphabet ? 2'd0 : 2'd2;
      end else begin
        job.sx[0] = held[15:10];
        job.sx[1] = {held[9:8], data_byte[7:4]};
        job.sx[2] = {data_byte[3:0], 2'd0};
        job.nsym = 3'd3;
        job.npad = url_alphabet ? 2'd0 : 2'd1;
      end
    end else begin
      held_next = (pos == 2'd0) ? {data_byte, 8'd0} : {held[15:8], data_byte};
      pos_next = pos + 2'd1;
    end
    if (last_byte) begin
      held_next = '0;
      pos_next = 2'd0;
      line_count_next = '0;
    end
  end

  assign q_push = accept && emit;
  assign q_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      url_alphabet <= 1'b0;
      max_line_length <= MAXLEN_RESET;
      held <= '0;
      pos <= '0;
      line_count <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_URL:    url_alphabet <= cfg_data[0];
          REG_MAXLEN: max_line_length <= cfg_data;
          default:    ;
        endcase
      end
      if (accept) begin
        held <= held_next;
        pos <= pos_next;
        line_count <= line_count_next;
      end
    end
  end

  `B64E_ASSERT_NOW(a_pos_range, 1'b1, pos != 2'd3, "group position out of range")
  `B64E_ASSERT_NEXT(a_last_clears, accept && last_byte, pos == 2'd0 && line_count == 11'd0,
                    "state not cleared after last beat")

endmodule

/* design/b64e_queue.sv */
module b64e_queue import b64e_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t head
);

  `include "base64_encoder_wrapped_unit_assert.svh"

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full = count == QCNT_W'(QDEPTH);
  assign valid = count != '0;
  assign head = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

  `B64E_ASSERT_NOW(a_no_overflow, push, !full, "push into full queue")
  `B64E_ASSERT_NOW(a_count_range, 1'b1, count <= QCNT_W'(QDEPTH), "queue count out of range")

endmodule

/* design/b64e_back.sv */
module b64e_back import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_char,
  output logic       out_last
);

  `include "base64_encoder_wrapped_unit_assert.svh"

  job_t       cur;
  logic       cur_valid;
  logic [2:0] idx;
  logic       out_valid;

  logic [2:0] total;
  logic [2:0] j;
  logic       is_last;
  logic [6:0] ch;
  logic       out_free;
  logic       advance;
  logic       load;

  always_comb begin
    total = {2'd0, cur.nl} + cur.nsym + {1'b0, cur.npad};
    is_last = idx == (total - 3'd1);
    j = idx - {2'd0, cur.nl};
    if (cur.nl && idx == 3'd0) ch = CHAR_NL;
    else if (j < cur.nsym) ch = sym(cur.sx[j[1:0]], cur.url);
    else ch = CHAR_PAD;
  end

  assign out_free = !out_valid || pop;
  assign advance = cur_valid && out_free;
  assign load = q_valid && (!cur_valid || (advance && is_last));
  assign q_pop = load;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      if (load) begin
        cur_valid <= 1'b1;
        idx <= '0;
      end else if (advance) begin
        if (is_last) cur_valid <= 1'b0;
        else idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) cur <= q_job;
    if (advance) begin
      out_char <= ch;
      out_last <= is_last;
    end
  end

  `B64E_ASSERT_NOW(a_idx_range, cur_valid, idx < total, "character index past end of group")
  `B64E_ASSERT_NEXT(a_drain, advance && is_last && !q_valid, !cur_valid,
                    "group still active after its last beat")

endmodule

/* design/base64_encoder_wrapped_unit.sv */
// channel  | ports                                 | beat when
// ---------+---------------------------------------+---------------------
// input    | push, full, data_byte, last_byte      | push & !full
// result   | empty, pop, out_char, out_last        | pop & !empty
// config   | cfg_write, cfg_index, cfg_data        | cfg_write
//
// Bytes are taken every cycle until the 4-entry group queue fills.
// The output side emits one character per cycle while pop is held:
// a 3-byte group gives 4 or 5 characters, a final partial group 2 to 4.
// A group goes through the queue, then the current-group register.
// rst is synchronous: clears group state, queue and output; registers
// return to standard alphabet and a 60-character line limit.
module base64_encoder_wrapped_unit import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_char,
  output logic       out_last
);

  logic q_push;
  job_t q_in;
  logic q_full;
  logic q_pop;
  logic q_valid;
  job_t q_head;

  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_in)
  );

  b64e_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  b64e_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_job    (q_head),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_char (out_char),
    .out_last (out_last)
  );

  assign full = q_full;

endmodule

/* dv/base64_encoder_wrapped_unit_checker.sv */
module base64_encoder_wrapped_unit_checker import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic [6:0] out_char,
  input  logic       out_last,
  output int         fail_count,
  output int         chars_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [511:0] STD_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [15:0] URL_TAIL = "-_";

  // {last, char} per expected beat, oldest first
  logic [7:0]  char_q[$];
  logic [7:0]  want;

  logic        url_mode;
  logic [9:0]  wrap_limit;
  logic [15:0] held_pair;
  logic [1:0]  fill;
  logic [10:0] column;

  function automatic logic [6:0] glyph(input logic [5:0] v);
    if (url_mode && v >= 6'd62) return URL_TAIL[8*(63 - v) +: 7];
    return STD_ALPHABET[8*(63 - v) +: 7];
  endfunction

  task automatic encode_byte(input logic [7:0] b, input logic lst);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [6:0] chars[$];
    b0 = held_pair[15:8];
    b1 = held_pair[7:0];
    if (fill >= 2'd2) begin
      if (wrap_limit != 10'd0 && column >= {1'b0, wrap_limit}) begin
        chars.push_back(CHAR_NL);
        column = '0;
      end
      chars.push_back(glyph(b0[7:2]));
      chars.push_back(glyph({b0[1:0], b1[7:4]}));
      chars.push_back(glyph({b1[3:0], b[7:6]}));
      chars.push_back(glyph(b[5:0]));
      column = (column > LINE_MAX - 11'd4) ? LINE_MAX : column + 11'd4;
      fill = '0;
      held_pair = '0;
    end else if (lst) begin
      if (fill == 2'd0) begin
        chars.push_back(glyph(b[7:2]));
        chars.push_back(glyph({b[1:0], 4'b0000}));
        if (!url_mode) begin
          chars.push_back(CHAR_PAD);
          chars.push_back(CHAR_PAD);
        end
      end else begin
        chars.push_back(glyph(b0[7:2]));
        chars.push_back(glyph({b0[1:0], b[7:4]}));
        chars.push_back(glyph({b[3:0], 2'b00}));
        if (!url_mode) chars.push_back(CHAR_PAD);
      end
    end else begin
      if (fill == 2'd0) held_pair = {b, 8'h00};
      else held_pair[7:0] = b;
      fill = fill + 2'd1;
    end
    if (lst) begin
      held_pair = '0;
      fill = '0;
      column = '0;
    end
    foreach (chars[i]) char_q.push_back({i == chars.size() - 1, chars[i]});
  endtask

  task automatic report(input string what);
    fail_count++;
    if (fail_count <= 10)
      $display("%t mismatch %s: expected char %h last %b, got char %h last %b",
               $realtime, what, want[6:0], want[7], out_char, out_last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      url_mode = 1'b0;
      wrap_limit = MAXLEN_RESET;
      held_pair = '0;
      fill = '0;
      column = '0;
      char_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_URL) url_mode = cfg_data[0];
        else wrap_limit = cfg_data;
      end
      if (pop && !empty) begin
        if (char_q.size() == 0) begin
          want = 'x;
          report("unexpected beat");
        end else begin
          want = char_q.pop_front();
          if (out_char !== want[6:0]) report("out_char");
          if (out_last !== want[7]) report("out_last");
        end
      end
      if (push && !full) encode_byte(data_byte, last_byte);
    end
    chars_due = char_q.size();
  end

endmodule

/* dv/base64_encoder_wrapped_unit_tb.sv */
module base64_encoder_wrapped_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import b64e_pkg::*;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic       cfg_index;
  logic [9:0] cfg_data;
  logic       push;
  logic       full;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       empty;
  logic       pop;
  logic [6:0] out_char;
  logic       out_last;
  int         fail_count;
  int         chars_due;
  logic       quiet;
  logic       hold_rx;

  base64_encoder_wrapped_unit dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .push, .full, .data_byte, .last_byte,
    .empty, .pop, .out_char, .out_last
  );

  base64_encoder_wrapped_unit_checker chk (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .push, .full, .data_byte, .last_byte,
    .empty, .pop, .out_char, .out_last,
    .fail_count, .chars_due
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    while (full) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // no register write until every expected beat is out and the pipe is drained
  task automatic drain_wait();
    push <= 1'b0;
    while (chars_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // caller drops cfg_write after the last write of a sequence
  task automatic write_reg(input logic idx, input logic [9:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic set_mode(input logic url, input logic [9:0] limit);
    drain_wait();
    write_reg(REG_URL, {9'd0, url});
    write_reg(REG_MAXLEN, limit);
    cfg_write <= 1'b0;
  endtask

  initial begin : drain
    pop = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_rx) begin
        hold_rx = 1'b0;
        pop <= 1'b0;
        repeat (80) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      pop <= 1'b1;
      @(negedge clk);
    end
  end

  initial begin : stim
    logic [9:0] limit_plan[8];
    int sent;
    int len;
    rst = 1'b1;
    push = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_URL;
    cfg_data = '0;
    data_byte = '0;
    last_byte = 1'b0;
    quiet = 1'b0;
    hold_rx = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values: standard alphabet, limit 60
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFB, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b0);
    send_byte(8'h80, 1'b1);

    // url alphabet, short lines: wrap before second group, no padding
    set_mode(1'b1, 10'd4);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b1);

    limit_plan = '{10'd0, 10'd1, 10'd1023, 10'd60, 10'($urandom_range(2, 1022)),
                   10'($urandom_range(2, 1022)), 10'd4, 10'd30};
    for (int p = 0; p < 8; p++) begin
      set_mode(p[0], limit_plan[p]);
      if (p == 2) hold_rx = 1'b1;
      if (p == 7) quiet = 1'b1;
      sent = 0;
      while (sent < 40) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 12);
        send_message(len);
        sent += len;
      end
    end

    drain_wait();
    repeat (12) @(negedge clk);
    if (fail_count == 0 && chars_due == 0) $display("base64_encoder_wrapped_unit_tb: PASS");
    else $display("base64_encoder_wrapped_unit_tb: FAIL");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("base64_encoder_wrapped_unit_tb: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/b64e_pkg.sv
design/b64e_front.sv
design/b64e_queue.sv
design/b64e_back.sv
design/base64_encoder_wrapped_unit.sv
dv/base64_encoder_wrapped_unit_checker.sv
dv/base64_encoder_wrapped_unit_tb.sv
